### hdl/gbfa_pkg.sv
// ----------------------------------------------------------------------------
// gbfa_pkg
// Shared types and code constants for the GB2312 font address decoder.
// ----------------------------------------------------------------------------
package gbfa_pkg;

  localparam logic [7:0]  HANZI_FIRST  = 8'hB0;
  localparam logic [7:0]  HANZI_LAST   = 8'hF7;
  localparam logic [7:0]  SYMBOL_FIRST = 8'hA1;
  localparam logic [7:0]  SYMBOL_LAST  = 8'hA3;
  localparam logic [7:0]  TRAIL_MIN    = 8'hA1;
  localparam logic [7:0]  ASCII_FIRST  = 8'h20;
  localparam logic [7:0]  ASCII_LAST   = 8'h7E;
  localparam logic [6:0]  ROW_CELLS    = 7'd94;
  localparam logic [12:0] HANZI_OFFSET = 13'd846;
  localparam logic [17:0] ASCII_BASE   = 18'h3CF80;
  localparam logic [7:0]  WIDE_STEP    = 8'd16;
  localparam logic [7:0]  NARROW_STEP  = 8'd8;

  typedef struct packed {
    logic [7:0] held_lead;
    logic       lead_pending;
    logic [7:0] cursor_column;
  } lead_state_t;

  typedef struct packed {
    logic        emit;
    logic        wide;
    logic [17:0] rom_address;
    logic [7:0]  column;
  } glyph_t;

endpackage

### hdl/gbfa_decode.sv
// ----------------------------------------------------------------------------
// gbfa_decode
// Per-byte decode: pairs lead and trail bytes, maps ASCII, computes the glyph
// address and the next lead and cursor state.
// ----------------------------------------------------------------------------
module gbfa_decode (
  input  logic [7:0]          text_byte,
  input  logic                new_string,
  input  logic [7:0]          start_column,
  input  gbfa_pkg::lead_state_t state_cur,
  output gbfa_pkg::lead_state_t state_nxt,
  output gbfa_pkg::glyph_t    glyph
);

  logic [7:0]  col_cur;
  logic        pend_cur;
  logic [7:0]  lead_cur;
  logic        lead_hanzi;
  logic [7:0]  row_full;
  logic [6:0]  row_idx;
  logic [7:0]  trail_full;
  logic [13:0] row_base;
  logic [13:0] cell_sum;
  logic [12:0] glyph_idx;
  logic [7:0]  ascii_off;
  logic        byte_is_lead;
  logic        byte_is_ascii;

  assign col_cur  = new_string ? start_column : state_cur.cursor_column;
  assign pend_cur = new_string ? 1'b0 : state_cur.lead_pending;
  assign lead_cur = new_string ? 8'd0 : state_cur.held_lead;

  assign lead_hanzi = (lead_cur >= gbfa_pkg::HANZI_FIRST);
  assign row_full   = lead_hanzi ? (lead_cur - gbfa_pkg::HANZI_FIRST)
                                 : (lead_cur - gbfa_pkg::SYMBOL_FIRST);
  assign row_idx    = row_full[6:0];
  assign trail_full = text_byte - gbfa_pkg::TRAIL_MIN;
  assign row_base   = {7'd0, row_idx} * {7'd0, gbfa_pkg::ROW_CELLS};
  assign cell_sum   = row_base + {7'd0, trail_full[6:0]}
                    + (lead_hanzi ? {1'b0, gbfa_pkg::HANZI_OFFSET} : 14'd0);
  assign glyph_idx  = cell_sum[12:0];
  assign ascii_off  = text_byte - gbfa_pkg::ASCII_FIRST;

  assign byte_is_lead =
    ((text_byte >= gbfa_pkg::HANZI_FIRST) && (text_byte <= gbfa_pkg::HANZI_LAST)) ||
    ((text_byte >= gbfa_pkg::SYMBOL_FIRST) && (text_byte <= gbfa_pkg::SYMBOL_LAST));
  assign byte_is_ascii =
    (text_byte >= gbfa_pkg::ASCII_FIRST) && (text_byte <= gbfa_pkg::ASCII_LAST);

  always_comb begin
    glyph.emit        = 1'b0;
    glyph.wide        = 1'b0;
    glyph.rom_address = {glyph_idx, 5'd0};
    glyph.column      = col_cur;
    state_nxt.held_lead    = 8'd0;
    state_nxt.lead_pending = 1'b0;
    if (pend_cur && (text_byte >= gbfa_pkg::TRAIL_MIN)) begin
      glyph.emit = 1'b1;
      glyph.wide = 1'b1;
    end else if (text_byte == 8'd0) begin
      glyph.emit = 1'b0;
    end else if (byte_is_lead) begin
      state_nxt.held_lead    = text_byte;
      state_nxt.lead_pending = 1'b1;
    end else if (byte_is_ascii) begin
      glyph.emit        = 1'b1;
      glyph.rom_address = {6'd0, ascii_off[6:0], 5'd0} >> 1;
      glyph.rom_address = glyph.rom_address + gbfa_pkg::ASCII_BASE;
    end
    if (glyph.emit) begin
      state_nxt.cursor_column = col_cur
        + (glyph.wide ? gbfa_pkg::WIDE_STEP : gbfa_pkg::NARROW_STEP);
    end else begin
      state_nxt.cursor_column = col_cur;
    end
  end

endmodule

### hdl/gb2312_font_address_decoder.sv
// ----------------------------------------------------------------------------
// gb2312_font_address_decoder
// Turns a mixed GB2312 / ASCII byte stream into font ROM glyph addresses with
// their display columns.
// ----------------------------------------------------------------------------
// One text byte is taken per clock cycle, sustained, while in_stall is low. A
// byte passes through an input register, is decoded combinationally against
// the held lead byte and the cursor, and its glyph (if any) lands in the
// output register. The output register is the only buffer: a stalled output
// holds back the input only when the byte in the input register would produce
// a glyph; bytes that produce none keep flowing. A double-byte glyph is
// emitted on its trail byte.
module gb2312_font_address_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_new_string,
  input  logic [7:0]  in_start_column,
  input  logic [2:0]  in_page,
  input  logic        in_invert,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [17:0] out_rom_address,
  output logic        out_wide_glyph,
  output logic [7:0]  out_glyph_column,
  output logic [2:0]  out_glyph_page,
  output logic        out_glyph_invert
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_new_r;
  logic [7:0]  s1_col_r;
  logic [2:0]  s1_page_r;
  logic        s1_inv_r;

  gbfa_pkg::lead_state_t state_r;
  gbfa_pkg::lead_state_t state_nxt;
  gbfa_pkg::glyph_t      glyph;

  logic        out_valid_r;
  logic [17:0] out_addr_r;
  logic        out_wide_r;
  logic [7:0]  out_col_r;
  logic [2:0]  out_page_r;
  logic        out_inv_r;

  logic out_free;
  logic s1_adv;
  logic in_take;

  gbfa_decode u_decode (
    .text_byte    (s1_byte_r),
    .new_string   (s1_new_r),
    .start_column (s1_col_r),
    .state_cur    (state_r),
    .state_nxt    (state_nxt),
    .glyph        (glyph)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!glyph.emit || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_text_byte;
      s1_new_r  <= in_new_string;
      s1_col_r  <= in_start_column;
      s1_page_r <= in_page;
      s1_inv_r  <= in_invert;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && glyph.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && glyph.emit) begin
      out_addr_r <= glyph.rom_address;
      out_wide_r <= glyph.wide;
      out_col_r  <= glyph.column;
      out_page_r <= s1_page_r;
      out_inv_r  <= s1_inv_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rom_address  = out_addr_r;
  assign out_wide_glyph   = out_wide_r;
  assign out_glyph_column = out_col_r;
  assign out_glyph_page   = out_page_r;
  assign out_glyph_invert = out_inv_r;

`ifndef SYNTHESIS
  a_pending_is_lead : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.lead_pending |->
      ((state_r.held_lead >= gbfa_pkg::HANZI_FIRST) &&
       (state_r.held_lead <= gbfa_pkg::HANZI_LAST)) ||
      ((state_r.held_lead >= gbfa_pkg::SYMBOL_FIRST) &&
       (state_r.held_lead <= gbfa_pkg::SYMBOL_LAST)))
    else $error("pending lead holds a non-lead byte");

  a_idle_lead_clear : assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.lead_pending |-> (state_r.held_lead == 8'd0))
    else $error("held lead not cleared");

  a_narrow_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wide_r) |->
      (out_addr_r >= gbfa_pkg::ASCII_BASE) && (out_addr_r[3:0] == 4'd0))
    else $error("narrow glyph address out of ascii area");

  a_wide_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_wide_r) |->
      (out_addr_r < gbfa_pkg::ASCII_BASE) && (out_addr_r[4:0] == 5'd0))
    else $error("wide glyph address out of hanzi area");

  a_zero_drops_lead : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_byte_r == 8'd0)) |=> !state_r.lead_pending)
    else $error("zero byte left a lead pending");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GB2312 font address decoder: a queue-fed driver
// sends text bytes in random bursts, a monitor compares every glyph beat with
// a behavioral decoder kept in step with the accepted input bytes.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_BEATS = 1800;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       new_string;
    logic [7:0] start_column;
    logic [2:0] page;
    logic       invert;
  } text_beat_t;

  typedef struct packed {
    logic [17:0] rom_address;
    logic        wide_glyph;
    logic [7:0]  glyph_column;
    logic [2:0]  glyph_page;
    logic        glyph_invert;
  } glyph_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = '0;
  logic        in_new_string = 1'b0;
  logic [7:0]  in_start_column = '0;
  logic [2:0]  in_page = '0;
  logic        in_invert = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [17:0] out_rom_address;
  logic        out_wide_glyph;
  logic [7:0]  out_glyph_column;
  logic [2:0]  out_glyph_page;
  logic        out_glyph_invert;

  text_beat_t  text_beats[$];
  glyph_beat_t glyph_queue[$];

  // decoder state mirrored from accepted bytes
  logic [7:0] lead_code = '0;
  logic       lead_held = 1'b0;
  logic [7:0] cursor_col = '0;

  int mismatches = 0;
  int glyphs_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int next_hold_at = 150;
  int mode_left = 0;
  int stall_mode = 0;
  int idle_cycles = 0;
  logic [31:0] cyc = '0;

  gb2312_font_address_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_new_string    (in_new_string),
    .in_start_column  (in_start_column),
    .in_page          (in_page),
    .in_invert        (in_invert),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rom_address  (out_rom_address),
    .out_wide_glyph   (out_wide_glyph),
    .out_glyph_column (out_glyph_column),
    .out_glyph_page   (out_glyph_page),
    .out_glyph_invert (out_glyph_invert)
  );

  always #1 clk = ~clk;

  task automatic push_glyph(input int unsigned addr, input logic wide,
                            input text_beat_t bt);
    glyph_beat_t g;
    g.rom_address  = addr[17:0];
    g.wide_glyph   = wide;
    g.glyph_column = cursor_col;
    g.glyph_page   = bt.page;
    g.glyph_invert = bt.invert;
    glyph_queue.push_back(g);
    cursor_col = cursor_col + (wide ? gbfa_pkg::WIDE_STEP : gbfa_pkg::NARROW_STEP);
  endtask

  task automatic decode_text_byte(input text_beat_t bt);
    int unsigned glyph_idx;
    logic [7:0] ch;
    ch = bt.text_byte;
    if (bt.new_string) begin
      cursor_col = bt.start_column;
      lead_held = 1'b0;
      lead_code = '0;
    end
    if (lead_held) begin
      lead_held = 1'b0;
      if (ch >= gbfa_pkg::TRAIL_MIN) begin
        if (lead_code >= gbfa_pkg::HANZI_FIRST) begin
          glyph_idx = (int'(lead_code) - int'(gbfa_pkg::HANZI_FIRST))
                      * int'(gbfa_pkg::ROW_CELLS)
                    + (int'(ch) - int'(gbfa_pkg::TRAIL_MIN))
                    + int'(gbfa_pkg::HANZI_OFFSET);
        end else begin
          glyph_idx = (int'(lead_code) - int'(gbfa_pkg::SYMBOL_FIRST))
                      * int'(gbfa_pkg::ROW_CELLS)
                    + (int'(ch) - int'(gbfa_pkg::TRAIL_MIN));
        end
        lead_code = '0;
        push_glyph(glyph_idx * 32, 1'b1, bt);
        return;
      end
      lead_code = '0;
    end
    if (ch == 8'h00) return;
    if ((ch >= gbfa_pkg::HANZI_FIRST && ch <= gbfa_pkg::HANZI_LAST) ||
        (ch >= gbfa_pkg::SYMBOL_FIRST && ch <= gbfa_pkg::SYMBOL_LAST)) begin
      lead_code = ch;
      lead_held = 1'b1;
      return;
    end
    if (ch >= gbfa_pkg::ASCII_FIRST && ch <= gbfa_pkg::ASCII_LAST) begin
      push_glyph(int'(gbfa_pkg::ASCII_BASE)
                 + (int'(ch) - int'(gbfa_pkg::ASCII_FIRST)) * 16, 1'b0, bt);
    end
  endtask

  task automatic add_beat(input int ch, input bit first, input int col);
    text_beat_t bt;
    bt.text_byte    = ch[7:0];
    bt.new_string   = first;
    bt.start_column = col[7:0];
    bt.page         = 3'($urandom_range(0, 7));
    bt.invert       = 1'($urandom_range(0, 1));
    text_beats.push_back(bt);
  endtask

  task automatic add_random_string();
    int tokens;
    int pick;
    tokens = $urandom_range(1, 14);
    add_beat(($urandom_range(0, 1) == 0)
             ? $urandom_range(gbfa_pkg::HANZI_FIRST, gbfa_pkg::HANZI_LAST)
             : $urandom_range(gbfa_pkg::ASCII_FIRST, gbfa_pkg::ASCII_LAST),
             1'b1, $urandom_range(0, 255));
    for (int i = 0; i < tokens; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        add_beat($urandom_range(gbfa_pkg::HANZI_FIRST, gbfa_pkg::HANZI_LAST), 1'b0,
                 $urandom_range(0, 255));
        add_beat($urandom_range(gbfa_pkg::TRAIL_MIN, 8'hFF), 1'b0,
                 $urandom_range(0, 255));
      end else if (pick < 48) begin
        add_beat($urandom_range(gbfa_pkg::SYMBOL_FIRST, gbfa_pkg::SYMBOL_LAST), 1'b0,
                 $urandom_range(0, 255));
        add_beat($urandom_range(gbfa_pkg::TRAIL_MIN, 8'hFF), 1'b0,
                 $urandom_range(0, 255));
      end else if (pick < 78) begin
        add_beat($urandom_range(gbfa_pkg::ASCII_FIRST, gbfa_pkg::ASCII_LAST), 1'b0,
                 $urandom_range(0, 255));
      end else if (pick < 88) begin
        add_beat($urandom_range(0, 255), $urandom_range(0, 15) == 0,
                 $urandom_range(0, 255));
      end else if (pick < 95) begin
        add_beat(($urandom_range(0, 1) == 0)
                 ? $urandom_range(gbfa_pkg::HANZI_FIRST, gbfa_pkg::HANZI_LAST)
                 : $urandom_range(gbfa_pkg::SYMBOL_FIRST, gbfa_pkg::SYMBOL_LAST),
                 1'b0, $urandom_range(0, 255));
        add_beat($urandom_range(0, gbfa_pkg::TRAIL_MIN - 1), 1'b0,
                 $urandom_range(0, 255));
      end else begin
        add_beat(8'h00, 1'b0, $urandom_range(0, 255));
      end
    end
    if ($urandom_range(0, 3) != 0) add_beat(8'h00, 1'b0, $urandom_range(0, 255));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_text_byte({in_text_byte, in_new_string, in_start_column, in_page,
                          in_invert});
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (text_beats.size() > 0) begin
          {in_text_byte, in_new_string, in_start_column, in_page, in_invert}
            <= text_beats.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                         : $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern with occasional long hold-off
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (glyphs_seen >= next_hold_at) begin
      next_hold_at = next_hold_at + 600;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        stall_mode = $urandom_range(0, 3);
      end
      mode_left = mode_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cyc[2] & cyc[0];
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    glyph_beat_t exp_g;
    if (rst_n && out_valid && !out_stall) begin
      glyphs_seen = glyphs_seen + 1;
      if (glyph_queue.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected glyph beat: addr %h wide %b col %0d page %0d inv %b",
                   out_rom_address, out_wide_glyph, out_glyph_column, out_glyph_page,
                   out_glyph_invert);
      end else begin
        exp_g = glyph_queue.pop_front();
        if (exp_g.rom_address !== out_rom_address || exp_g.wide_glyph !== out_wide_glyph ||
            exp_g.glyph_column !== out_glyph_column || exp_g.glyph_page !== out_glyph_page ||
            exp_g.glyph_invert !== out_glyph_invert) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"glyph mismatch: exp addr %h wide %b col %0d page %0d inv %b, ",
                      "got addr %h wide %b col %0d page %0d inv %b"},
                     exp_g.rom_address, exp_g.wide_glyph, exp_g.glyph_column,
                     exp_g.glyph_page, exp_g.glyph_invert, out_rom_address,
                     out_wide_glyph, out_glyph_column, out_glyph_page, out_glyph_invert);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int base_len;
    // directed: extremes, skipped bytes, broken and chained leads, wrap
    add_beat(8'h41, 1'b1, 0);
    add_beat(8'h20, 1'b0, 0);
    add_beat(8'h7E, 1'b0, 0);
    add_beat(8'h1F, 1'b0, 0);
    add_beat(8'h7F, 1'b0, 0);
    add_beat(8'hB0, 1'b0, 0);
    add_beat(8'hA1, 1'b0, 0);
    add_beat(8'hF7, 1'b0, 0);
    add_beat(8'hFE, 1'b0, 0);
    add_beat(8'hA1, 1'b0, 0);
    add_beat(8'hA1, 1'b0, 0);
    add_beat(8'hA3, 1'b0, 0);
    add_beat(8'hFF, 1'b0, 0);
    add_beat(8'hB0, 1'b0, 0);
    add_beat(8'h41, 1'b0, 0);
    add_beat(8'hC5, 1'b0, 0);
    add_beat(8'h00, 1'b0, 0);
    add_beat(8'h5A, 1'b0, 0);
    add_beat(8'hB0, 1'b0, 0);
    add_beat(8'hB0, 1'b0, 0);
    add_beat(8'hA4, 1'b0, 0);
    add_beat(8'hF8, 1'b0, 0);
    add_beat(8'hA2, 1'b0, 0);
    add_beat(8'h78, 1'b1, 255);
    add_beat(8'hF7, 1'b1, 248);
    add_beat(8'hA1, 1'b0, 0);
    base_len = text_beats.size();
    while (text_beats.size() < base_len + RANDOM_BEATS) add_random_string();

    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (text_beats.size() > 0 || in_valid || glyph_queue.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && glyph_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### sim.f
hdl/gbfa_pkg.sv
hdl/gbfa_decode.sv
hdl/gb2312_font_address_decoder.sv
tb/sv/tb.sv
